### sv/packet_deframer_with_payload_fifo_macros.svh
// ----------------------------------------------------------------------------
// Packet deframer assertion macros
// Shared assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_WITH_PAYLOAD_FIFO_MACROS_SVH
`define PACKET_DEFRAMER_WITH_PAYLOAD_FIFO_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define PDF_ASSERT_IMPLIES(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pdf assertion failed");

// Consequent holds in the cycle after the antecedent.
`define PDF_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pdf assertion failed");

`endif

### sv/pdf_pkg.sv
// ----------------------------------------------------------------------------
// Packet deframer package
// Transaction types, status codes, framing constants and the CRC step.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int LEN_W = 10;

    localparam int DEF_MAX_PAYLOAD = 700;
    localparam int DEF_QUEUE_SLOTS = 4;

    localparam logic CMD_RX  = 1'b0;
    localparam logic CMD_POP = 1'b1;

    localparam logic [2:0] ST_IGNORED    = 3'd0;
    localparam logic [2:0] ST_IN_FRAME   = 3'd1;
    localparam logic [2:0] ST_QUEUED     = 3'd2;
    localparam logic [2:0] ST_DROPPED    = 3'd3;
    localparam logic [2:0] ST_CRC_BAD    = 3'd4;
    localparam logic [2:0] ST_LEN_REJECT = 3'd5;
    localparam logic [2:0] ST_POP_DATA   = 3'd6;
    localparam logic [2:0] ST_POP_EMPTY  = 3'd7;

    localparam logic [7:0]  START_SHORT = 8'd2;
    localparam logic [7:0]  START_LONG  = 8'd4;
    localparam logic [7:0]  END_MARK    = 8'd3;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             accepted;
        logic [7:0]       payload_byte;
        logic             payload_last;
        logic [LEN_W-1:0] payload_length;
        logic [2:0]       pending_count;
        logic [31:0]      good_frames;
        logic [31:0]      bad_frames;
        logic [31:0]      dropped_frames;
    } result_t;

    // framer -> queue: payload byte write into the slot being filled
    typedef struct packed {
        logic             we;
        logic [LEN_W-1:0] offset;
        logic [7:0]       data;
    } store_wr_t;

    // framer -> queue: frame complete, push the filled slot
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] length;
    } commit_t;

    typedef struct packed {
        logic [2:0] status;
        logic       accepted;
        logic       idle;
    } fr_res_t;

    typedef struct packed {
        logic [2:0] status;
        logic       last;
    } pop_res_t;

    // CRC-16/XMODEM, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

### sv/pdf_framer.sv
// ----------------------------------------------------------------------------
// Packet deframer: frame parser
// Walks start, length, payload, CRC and end bytes; checks CRC and counts frames.
// ----------------------------------------------------------------------------
module pdf_framer #(
    parameter int MAX_PAYLOAD = pdf_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [7:0]          rx_byte,
    input  logic                full,
    output pdf_pkg::store_wr_t  wr,
    output pdf_pkg::commit_t    commit,
    output pdf_pkg::fr_res_t    res,
    output logic [31:0]         good_frames,
    output logic [31:0]         bad_frames,
    output logic [31:0]         dropped_frames
);
    import pdf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LEN    = 3'd1;
    localparam logic [2:0] S_DATA   = 3'd2;
    localparam logic [2:0] S_CRC_HI = 3'd3;
    localparam logic [2:0] S_CRC_LO = 3'd4;
    localparam logic [2:0] S_END    = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       len_left_reg, len_left_next;
    logic [15:0]      frame_len_reg, frame_len_next;
    logic [LEN_W-1:0] offset_reg, offset_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      rcrc_reg, rcrc_next;
    logic             lost_reg, lost_next;
    logic [31:0]      good_reg, good_next;
    logic [31:0]      bad_reg, bad_next;
    logic [31:0]      drop_reg, drop_next;

    logic [15:0]      len_v;
    logic [7:0]       kind;
    logic [LEN_W-1:0] offset_inc;

    // length accumulates big-endian and saturates at 16 bits
    assign len_v      = (frame_len_reg[15:8] != 8'h00) ? 16'hFFFF : {frame_len_reg[7:0], rx_byte};
    assign kind       = rx_byte - 8'd1;
    assign offset_inc = offset_reg + LEN_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        len_left_next  = len_left_reg;
        frame_len_next = frame_len_reg;
        offset_next    = offset_reg;
        crc_next       = crc_reg;
        rcrc_next      = rcrc_reg;
        lost_next      = lost_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        drop_next      = drop_reg;
        wr.we          = 1'b0;
        wr.offset      = offset_reg;
        wr.data        = rx_byte;
        commit.valid   = 1'b0;
        commit.length  = frame_len_reg[LEN_W-1:0];
        res.status     = ST_IGNORED;
        res.accepted   = 1'b0;
        res.idle       = (state_reg == S_IDLE);

        if (go)
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (rx_byte >= START_SHORT && rx_byte <= START_LONG)
                    begin
                        state_next     = S_LEN;
                        len_left_next  = kind[1:0];
                        frame_len_next = 16'h0000;
                        crc_next       = 16'h0000;
                        rcrc_next      = 16'h0000;
                        lost_next      = 1'b0;
                        res.status     = ST_IN_FRAME;
                        res.accepted   = 1'b1;
                    end
                end
                S_LEN:
                begin
                    res.accepted   = 1'b1;
                    res.status     = ST_IN_FRAME;
                    frame_len_next = len_v;
                    len_left_next  = len_left_reg - 2'd1;
                    if (len_left_reg == 2'd1)
                    begin
                        if (len_v == 16'h0000 || len_v > 16'(MAX_PAYLOAD))
                        begin
                            state_next = S_IDLE;
                            res.status = ST_LEN_REJECT;
                        end
                        else
                        begin
                            state_next  = S_DATA;
                            offset_next = '0;
                        end
                    end
                end
                S_DATA:
                begin
                    res.accepted = 1'b1;
                    res.status   = ST_IN_FRAME;
                    // a byte lost to a full queue spoils the whole frame
                    if (full)
                    begin
                        lost_next = 1'b1;
                    end
                    else
                    begin
                        wr.we = 1'b1;
                    end
                    crc_next    = crc16_byte(crc_reg, rx_byte);
                    offset_next = offset_inc;
                    if (offset_inc == frame_len_reg[LEN_W-1:0])
                    begin
                        state_next = S_CRC_HI;
                    end
                end
                S_CRC_HI:
                begin
                    res.accepted = 1'b1;
                    res.status   = ST_IN_FRAME;
                    rcrc_next    = {rx_byte, 8'h00};
                    state_next   = S_CRC_LO;
                end
                S_CRC_LO:
                begin
                    res.accepted = 1'b1;
                    res.status   = ST_IN_FRAME;
                    rcrc_next    = {rcrc_reg[15:8], rx_byte};
                    state_next   = S_END;
                end
                S_END:
                begin
                    res.accepted = 1'b1;
                    state_next   = S_IDLE;
                    if (rx_byte == END_MARK && rcrc_reg == crc_reg)
                    begin
                        good_next = good_reg + 32'd1;
                        if (!full && !lost_reg)
                        begin
                            commit.valid = 1'b1;
                            res.status   = ST_QUEUED;
                        end
                        else
                        begin
                            drop_next  = drop_reg + 32'd1;
                            res.status = ST_DROPPED;
                        end
                    end
                    else
                    begin
                        bad_next   = bad_reg + 32'd1;
                        res.status = ST_CRC_BAD;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_left_reg  <= 2'd0;
            frame_len_reg <= 16'h0000;
            offset_reg    <= '0;
            crc_reg       <= 16'h0000;
            rcrc_reg      <= 16'h0000;
            lost_reg      <= 1'b0;
            good_reg      <= 32'd0;
            bad_reg       <= 32'd0;
            drop_reg      <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            len_left_reg  <= len_left_next;
            frame_len_reg <= frame_len_next;
            offset_reg    <= offset_next;
            crc_reg       <= crc_next;
            rcrc_reg      <= rcrc_next;
            lost_reg      <= lost_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            drop_reg      <= drop_next;
        end
    end

    assign good_frames    = good_reg;
    assign bad_frames     = bad_reg;
    assign dropped_frames = drop_reg;

endmodule

### sv/pdf_queue.sv
// ----------------------------------------------------------------------------
// Packet deframer: payload queue
// Slot ring over one byte memory; fills the head slot, pops from the tail slot.
// ----------------------------------------------------------------------------
module pdf_queue #(
    parameter int MAX_PAYLOAD = pdf_pkg::DEF_MAX_PAYLOAD,
    parameter int QUEUE_SLOTS = pdf_pkg::DEF_QUEUE_SLOTS,
    parameter int COUNT_W     = $clog2(QUEUE_SLOTS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop,
    input  pdf_pkg::store_wr_t        wr,
    input  pdf_pkg::commit_t          commit,
    output logic                      full,
    output pdf_pkg::pop_res_t         pop_res,
    output logic [7:0]                rd_data,
    output logic [pdf_pkg::LEN_W-1:0] head_len,
    output logic [COUNT_W-1:0]        count
);
    import pdf_pkg::*;

    localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int DEPTH  = QUEUE_SLOTS * MAX_PAYLOAD;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;

    logic [SLOT_W-1:0] head_reg, tail_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [LEN_W-1:0]  pop_off_reg;
    logic [LEN_W-1:0]  slot_len_reg [QUEUE_SLOTS];

    logic [SLOT_W-1:0] head_inc, tail_inc;
    logic [LEN_W-1:0]  tail_len;
    logic              not_empty;
    logic              pop_hit;
    logic              pop_last;
    logic [LEN_W:0]    pop_off_inc;
    logic [ADDR_W-1:0] waddr, raddr;

    assign head_inc  = (head_reg == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : head_reg + SLOT_W'(1);
    assign tail_inc  = (tail_reg == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : tail_reg + SLOT_W'(1);
    assign tail_len  = slot_len_reg[tail_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == COUNT_W'(QUEUE_SLOTS));
    assign pop_hit   = pop && not_empty;

    assign pop_off_inc = {1'b0, pop_off_reg} + (LEN_W+1)'(1);
    assign pop_last    = (pop_off_inc >= {1'b0, tail_len});

    assign waddr = ADDR_W'(head_reg) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(wr.offset);
    assign raddr = ADDR_W'(tail_reg) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(pop_off_reg);

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[waddr] <= wr.data;
        end
        if (pop_hit)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            pop_off_reg <= '0;
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                slot_len_reg[i] <= '0;
            end
        end
        else
        begin
            // commit and pop come from different transactions, never together
            if (commit.valid)
            begin
                slot_len_reg[head_reg] <= commit.length;
                head_reg               <= head_inc;
                count_reg              <= count_reg + COUNT_W'(1);
            end
            else if (pop_hit)
            begin
                if (pop_last)
                begin
                    slot_len_reg[tail_reg] <= '0;
                    tail_reg               <= tail_inc;
                    count_reg              <= count_reg - COUNT_W'(1);
                    pop_off_reg            <= '0;
                end
                else
                begin
                    pop_off_reg <= pop_off_inc[LEN_W-1:0];
                end
            end
        end
    end

    assign pop_res.status = not_empty ? ST_POP_DATA : ST_POP_EMPTY;
    assign pop_res.last   = pop_hit && pop_last;
    assign rd_data        = rd_data_reg;
    assign head_len       = not_empty ? tail_len : '0;
    assign count          = count_reg;

endmodule

### sv/packet_deframer_with_payload_fifo.sv
// ----------------------------------------------------------------------------
// Packet deframer with payload FIFO
// Parses start/length/payload/CRC/end frames and queues good payloads.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): cmd 0 feeds one line byte to
//   the framer, cmd 1 pops one byte of the oldest queued payload.
//   result channel (result_valid/result_ready/result): exactly one result per
//   transaction, in order, with status, popped byte and queue/counter status.
// A result is registered and is valid in the cycle after its item is taken.
// Throughput: one item per cycle unless stalled; the CRC step and one payload
//   memory access (write on receive, registered read on pop) fit in the cycle.
// Payload bytes are written into the free head slot as they arrive; the
//   memory is QUEUE_SLOTS * MAX_PAYLOAD bytes and needs no clearing pass.
// Reset: framer idle, queue empty, all frame counters zero; block is ready
//   to take items as soon as reset is released.
// Stall: while result_valid is high and result_ready is low the result holds
//   and item_ready drops, so no state moves until the result is taken.
// ----------------------------------------------------------------------------
`include "packet_deframer_with_payload_fifo_macros.svh"

module packet_deframer_with_payload_fifo #(
    parameter int MAX_PAYLOAD = pdf_pkg::DEF_MAX_PAYLOAD,
    parameter int QUEUE_SLOTS = pdf_pkg::DEF_QUEUE_SLOTS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  pdf_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output pdf_pkg::result_t result
);
    import pdf_pkg::*;

    localparam int COUNT_W = $clog2(QUEUE_SLOTS + 1);

    logic               item_fire;
    logic               fr_go;
    logic               q_pop;

    store_wr_t          wr;
    commit_t            commit;
    fr_res_t            fr_res;
    pop_res_t           pop_res;
    logic               q_full;
    logic [7:0]         q_rd_data;
    logic [LEN_W-1:0]   q_head_len;
    logic [COUNT_W-1:0] q_count;
    logic [31:0]        count_w;
    logic [31:0]        good_frames, bad_frames, dropped_frames;

    logic               out_valid_reg;
    logic [2:0]         status_reg;
    logic               accepted_reg;
    logic               last_reg;

    assign item_ready = !out_valid_reg || result_ready;
    assign item_fire  = item_valid && item_ready;
    assign fr_go      = item_fire && (item.cmd == CMD_RX);
    assign q_pop      = item_fire && (item.cmd == CMD_POP);

    pdf_framer #(
        .MAX_PAYLOAD    (MAX_PAYLOAD)
    ) u_framer (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (fr_go),
        .rx_byte        (item.rx_byte),
        .full           (q_full),
        .wr             (wr),
        .commit         (commit),
        .res            (fr_res),
        .good_frames    (good_frames),
        .bad_frames     (bad_frames),
        .dropped_frames (dropped_frames)
    );

    pdf_queue #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .COUNT_W     (COUNT_W)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop         (q_pop),
        .wr          (wr),
        .commit      (commit),
        .full        (q_full),
        .pop_res     (pop_res),
        .rd_data     (q_rd_data),
        .head_len    (q_head_len),
        .count       (q_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            if (item.cmd == CMD_POP)
            begin
                status_reg   <= pop_res.status;
                accepted_reg <= 1'b0;
                last_reg     <= pop_res.last;
            end
            else
            begin
                status_reg   <= fr_res.status;
                accepted_reg <= fr_res.accepted;
                last_reg     <= 1'b0;
            end
        end
    end

    // state only moves on a taken item, so while a result is held the live
    // queue and counter registers already show the state after that item
    assign count_w = 32'(q_count);

    assign result_valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.accepted       = accepted_reg;
    assign result.payload_byte   = (status_reg == ST_POP_DATA) ? q_rd_data : 8'h00;
    assign result.payload_last   = last_reg;
    assign result.payload_length = q_head_len;
    assign result.pending_count  = count_w[2:0];
    assign result.good_frames    = good_frames;
    assign result.bad_frames     = bad_frames;
    assign result.dropped_frames = dropped_frames;

    `PDF_ASSERT_NEXT(a_pop_empty, q_pop && (q_count == '0), result_valid && (result.status == ST_POP_EMPTY))
    `PDF_ASSERT_NEXT(a_idle_ignore, fr_go && fr_res.idle && (item.rx_byte < START_SHORT || item.rx_byte > START_LONG), result_valid && (result.status == ST_IGNORED) && !result.accepted)
    `PDF_ASSERT_IMPLIES(a_commit_room, commit.valid, !q_full)
    `PDF_ASSERT_IMPLIES(a_head_len, q_count != '0, q_head_len != '0)

endmodule
